>>> hdl/bnfd_pkg.sv
package bnfd_pkg;

	localparam int FRAME_BYTES = 11;
	localparam int PTR_W = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W = $clog2(FRAME_BYTES);

	localparam int ID_BITS    = 32;
	localparam int VOL_BITS   = 12;
	localparam int ID_DIGITS  = 10;
	localparam int VOL_DIGITS = 4;
	localparam int STEP_W     = $clog2(ID_BITS);

	localparam logic [3:0] ERROR_LIMIT_RESET = 4'd3;
	localparam logic [7:0] HEADER_BASE       = 8'hA0;
	localparam logic [11:0] VOL_MASK         = 12'hFFF;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_EVAL  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_CHECK,
		ST_CONV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		BAT_OTHER  = 2'd0,
		BAT_STAT10 = 2'd1,
		BAT_STAT01 = 2'd2,
		BAT_STAT00 = 2'd3
	} bat_status_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_stat_t;

	function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
		return (d >= 4'd5) ? 4'(d + 4'd3) : d;
	endfunction

	function automatic bat_status_t map_status(input logic [7:0] b);
		bat_status_t s;
		unique case (b)
			8'h10:   s = BAT_STAT10;
			8'h01:   s = BAT_STAT01;
			8'h00:   s = BAT_STAT00;
			default: s = BAT_OTHER;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/bnfd_dabble.sv
module bnfd_dabble (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [bnfd_pkg::ID_BITS-1:0]         id_bin,
	input  logic [bnfd_pkg::VOL_BITS-1:0]        vol_bin,
	output bnfd_pkg::conv_stat_t                 stat,
	output logic [4*bnfd_pkg::ID_DIGITS-1:0]     id_bcd,
	output logic [4*bnfd_pkg::VOL_DIGITS-1:0]    vol_bcd
);

	localparam int IDW = 4 * bnfd_pkg::ID_DIGITS;
	localparam int VW  = 4 * bnfd_pkg::VOL_DIGITS;
	localparam logic [bnfd_pkg::STEP_W-1:0] LAST_STEP =
		bnfd_pkg::STEP_W'(bnfd_pkg::ID_BITS - 1);
	localparam logic [bnfd_pkg::STEP_W-1:0] VOL_FIRST =
		bnfd_pkg::STEP_W'(bnfd_pkg::ID_BITS - bnfd_pkg::VOL_BITS);

	logic                            busy_q, done_q;
	logic [bnfd_pkg::STEP_W-1:0]     step_q;
	logic [bnfd_pkg::ID_BITS-1:0]    bin_q;
	logic [bnfd_pkg::VOL_BITS-1:0]   vbin_q;
	logic [IDW-1:0]                  idb_q, id_adj;
	logic [VW-1:0]                   vb_q, vol_adj;

	// add-3 correction per digit ahead of each shift
	always_comb begin
		for (int i = 0; i < bnfd_pkg::ID_DIGITS; i++) begin
			id_adj[4*i +: 4] = bnfd_pkg::bcd_adjust(idb_q[4*i +: 4]);
		end
		for (int i = 0; i < bnfd_pkg::VOL_DIGITS; i++) begin
			vol_adj[4*i +: 4] = bnfd_pkg::bcd_adjust(vb_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q  <= id_bin;
			vbin_q <= vol_bin;
			idb_q  <= '0;
			vb_q   <= '0;
		end else if (busy_q) begin
			idb_q <= {id_adj[IDW-2:0], bin_q[bnfd_pkg::ID_BITS-1]};
			bin_q <= {bin_q[bnfd_pkg::ID_BITS-2:0], 1'b0};
			if (step_q >= VOL_FIRST) begin
				vb_q   <= {vol_adj[VW-2:0], vbin_q[bnfd_pkg::VOL_BITS-1]};
				vbin_q <= {vbin_q[bnfd_pkg::VOL_BITS-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign id_bcd    = idb_q;
	assign vol_bcd   = vb_q;

endmodule

>>> hdl/battery_node_frame_decoder.sv
// channel  dir  signals                      content
// s_*      in   tvalid tready tdata tuser    command, received byte, node number
// m_*      out  tvalid tready tdata tuser    frame result and decoded fields
// cfg_*    in   we data                      error_limit register
//
// Start and byte commands are taken while s_tready is high. Evaluate sums bytes 0 to 9
// through the checksum adder and, on a good frame, then runs the 32 steps of the
// shift/add-3 BCD converter; a bad frame skips the conversion. s_tready is low meanwhile.
// Reset clears control state and the fill pointer; frame bytes past the pointer read as zero.
// A result waits in the output register; a new evaluate holds in its last state until it is taken.
module battery_node_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // rx_byte[7:0], node_number[11:8], zero[15:12]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // node_id[3:0], id_type_byte[11:4], id_code_byte[19:12],
	                              // id_decimal_bcd[59:20], voltage_bcd[75:60],
	                              // battery_status[77:76], lock_state[78], zero[79]
	output logic [1:0]  m_tuser,  // frame_ok[0], node_dropped[1]
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data
);

	localparam int NB = bnfd_pkg::FRAME_BYTES;
	localparam logic [bnfd_pkg::IDX_W-1:0] LAST_SUM = bnfd_pkg::IDX_W'(NB - 2);
	localparam logic [bnfd_pkg::PTR_W-1:0] PTR_FULL = bnfd_pkg::PTR_W'(NB);

	bnfd_pkg::state_t state_q, state_d;

	logic [7:0]                  frame_q [NB];
	logic [bnfd_pkg::PTR_W-1:0]  ptr_q;
	logic [bnfd_pkg::IDX_W-1:0]  idx_q;
	logic [7:0]                  sum_q;
	logic [3:0]                  err_q, limit_q, node_q;
	logic                        active_q;
	logic                        ok_q, drop_q;
	logic [7:0]                  type_q, code_q;
	logic [1:0]                  stat_q;
	logic                        lock_q;
	logic                        out_valid_q;
	logic [79:0]                 out_data_q;
	logic [1:0]                  out_user_q;

	logic                        accept, is_eval, frame_good, out_free, conv_start;
	logic [4:0]                  err_next;
	bnfd_pkg::cmd_t              cmd;
	bnfd_pkg::conv_stat_t        conv_stat;
	logic [39:0]                 id_bcd;
	logic [15:0]                 vol_bcd;
	logic [7:0]                  b [NB];

	// bytes beyond the fill pointer were never received and read as zero
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			b[i] = (bnfd_pkg::PTR_W'(i) < ptr_q) ? frame_q[i] : 8'h00;
		end
	end

	assign cmd        = bnfd_pkg::cmd_t'(s_tuser);
	assign accept     = s_tvalid && s_tready;
	assign is_eval    = accept && (cmd == bnfd_pkg::CMD_EVAL) && active_q;
	assign frame_good = (b[0] == ~(bnfd_pkg::HEADER_BASE | {4'h0, node_q}))
	                    && (sum_q == b[NB-1]);
	assign out_free   = !out_valid_q || m_tready;
	assign err_next   = {1'b0, err_q} + 5'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bnfd_pkg::ST_IDLE:  if (is_eval) state_d = bnfd_pkg::ST_SUM;
			bnfd_pkg::ST_SUM:   if (idx_q == LAST_SUM) state_d = bnfd_pkg::ST_CHECK;
			bnfd_pkg::ST_CHECK: state_d = frame_good ? bnfd_pkg::ST_CONV : bnfd_pkg::ST_DONE;
			bnfd_pkg::ST_CONV:  if (conv_stat.done) state_d = bnfd_pkg::ST_DONE;
			bnfd_pkg::ST_DONE:  if (out_free) state_d = bnfd_pkg::ST_IDLE;
			default:            state_d = bnfd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == bnfd_pkg::ST_IDLE);
		conv_start = (state_q == bnfd_pkg::ST_CHECK) && frame_good;
	end

	bnfd_dabble u_dabble (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (conv_start),
		.id_bin  ({b[6], b[5], b[4], b[3]}),
		.vol_bin ({b[7][3:0], b[8]} & bnfd_pkg::VOL_MASK),
		.stat    (conv_stat),
		.id_bcd  (id_bcd),
		.vol_bcd (vol_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bnfd_pkg::ST_IDLE;
			ptr_q       <= '0;
			idx_q       <= '0;
			err_q       <= '0;
			limit_q     <= bnfd_pkg::ERROR_LIMIT_RESET;
			node_q      <= '0;
			active_q    <= 1'b0;
			ok_q        <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (accept && (cmd == bnfd_pkg::CMD_START)) begin
				ptr_q    <= '0;
				node_q   <= s_tdata[11:8];
				active_q <= 1'b1;
			end
			if (accept && (cmd == bnfd_pkg::CMD_BYTE) && active_q && (ptr_q < PTR_FULL)) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (is_eval) begin
				idx_q <= '0;
			end else if (state_q == bnfd_pkg::ST_SUM) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == bnfd_pkg::ST_CHECK) begin
				ptr_q  <= '0;
				ok_q   <= frame_good;
				drop_q <= 1'b0;
				if (frame_good) begin
					active_q <= 1'b0;
				end else if (err_next > {1'b0, limit_q}) begin
					err_q    <= '0;
					active_q <= 1'b0;
					drop_q   <= 1'b1;
				end else begin
					err_q <= err_next[3:0];
				end
			end
			if ((state_q == bnfd_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == bnfd_pkg::CMD_BYTE) && active_q && (ptr_q < PTR_FULL)) begin
			frame_q[ptr_q[bnfd_pkg::IDX_W-1:0]] <= s_tdata[7:0];
		end
		if (is_eval) begin
			sum_q <= 8'h00;
		end else if (state_q == bnfd_pkg::ST_SUM) begin
			sum_q <= sum_q + b[idx_q];
		end
		if (state_q == bnfd_pkg::ST_CHECK) begin
			type_q <= b[1];
			code_q <= b[2];
			stat_q <= bnfd_pkg::map_status(b[9]);
			lock_q <= b[7][4];
		end
		if ((state_q == bnfd_pkg::ST_DONE) && out_free) begin
			out_user_q <= {drop_q, ok_q};
			if (ok_q) begin
				out_data_q <= {1'b0, lock_q, stat_q, vol_bcd, id_bcd, code_q, type_q, node_q};
			end else begin
				out_data_q <= {76'h0, node_q};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> hdl/bnfd_checker.sv
module bnfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("good frame reported as dropped");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[79:4] == 76'h0)
		else $error("bad frame carries field data");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != bnfd_pkg::CMD_EVAL |=> !$rose(m_tvalid))
		else $error("result without evaluate");

endmodule

bind battery_node_frame_decoder bnfd_checker u_bnfd_checker (.*);
